// File: rtl/core/udr_pkg.sv
`default_nettype none

package udr_pkg;

   // Sequencer states of the integration step.
   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL_ACC,
      S_MUL_YAW,
      S_HEAD,
      S_CORDIC,
      S_MUL_C,
      S_MUL_S,
      S_POS_Y,
      S_OUT
   } state_type;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      REG_STEP_TIME     = 3'd0,
      REG_START_X       = 3'd1,
      REG_START_Y       = 3'd2,
      REG_START_SPEED   = 3'd3,
      REG_START_HEADING = 3'd4
   } reg_index_type;

   // Heading quadrants taken from the two top angle bits.
   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   localparam int MAX_ITERS    = 24;
   localparam int ITER_IDX_W   = 5;
   localparam int CORDIC_W     = 20;
   localparam int ANGLE_W      = 32;
   localparam int MUL_A_W      = 33;
   localparam int MUL_P_W      = MUL_A_W + CORDIC_W;

   localparam logic [15:0] STEP_TIME_RESET = 16'd655;
   localparam logic signed [CORDIC_W-1:0] CORDIC_START = 20'sd39797;

   // Arctangent of 2^-i in units of 2^32 per turn.
   function automatic logic signed [ANGLE_W-1:0] atan_turn(input logic [ITER_IDX_W-1:0] idx);
      logic signed [ANGLE_W-1:0] val;
      case (idx)
         5'd0:  val = 32'sd536870912;
         5'd1:  val = 32'sd316933406;
         5'd2:  val = 32'sd167458907;
         5'd3:  val = 32'sd85004756;
         5'd4:  val = 32'sd42667331;
         5'd5:  val = 32'sd21354465;
         5'd6:  val = 32'sd10679838;
         5'd7:  val = 32'sd5340245;
         5'd8:  val = 32'sd2670163;
         5'd9:  val = 32'sd1335087;
         5'd10: val = 32'sd667544;
         5'd11: val = 32'sd333772;
         5'd12: val = 32'sd166886;
         5'd13: val = 32'sd83443;
         5'd14: val = 32'sd41722;
         5'd15: val = 32'sd20861;
         5'd16: val = 32'sd10430;
         5'd17: val = 32'sd5215;
         5'd18: val = 32'sd2608;
         5'd19: val = 32'sd1304;
         5'd20: val = 32'sd652;
         5'd21: val = 32'sd326;
         5'd22: val = 32'sd163;
         5'd23: val = 32'sd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/unicycle_dead_reckoning_step_core.sv
// A request runs through the multiplies of the shared multiplier, the heading update, the
// CORDIC loop of one rotation per cycle and the position updates; the result of a request
// marked last is then written to an output register, where it waits until it is taken.
// A new request is accepted only in the idle state, once the previous one is through.
// A last request that finds the output register still full waits until the result is taken.
// Reset (synchronous): state, position and start values clear to zero, step_time is 655.
`default_nettype none

module unicycle_dead_reckoning_step_core #(
   parameter int SINCOS_ITERATIONS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [15:0] acceleration, [31:16] turn rate
   input  wire logic        req_tuser,   // [0] restart
   input  wire logic        req_tlast,   // last_substep
   // Result channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [95:0]      rsp_tdata,   // [31:0] x_position, [63:32] y_position,
                                         // [79:64] speed, [95:80] heading
   // Register write port.
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int ITERS = (SINCOS_ITERATIONS > udr_pkg::MAX_ITERS) ?
                          udr_pkg::MAX_ITERS : SINCOS_ITERATIONS;
   localparam int IW = udr_pkg::ITER_IDX_W;
   localparam int CW = udr_pkg::CORDIC_W;
   localparam int AW = udr_pkg::ANGLE_W;
   localparam int MA = udr_pkg::MUL_A_W;
   localparam int MP = udr_pkg::MUL_P_W;

   // Configuration registers.
   logic [15:0] step_time_ff;
   logic [31:0] start_x_ff;
   logic [31:0] start_y_ff;
   logic [15:0] start_speed_ff;
   logic [15:0] start_heading_ff;

   udr_pkg::state_type state_ff, state_in;
   logic [IW-1:0]      iter_ff, iter_in;
   logic signed [15:0] acc_ff, acc_in;
   logic signed [15:0] yaw_ff, yaw_in;
   logic               last_ff, last_in;

   logic signed [31:0] pos_x_ff, pos_x_in;
   logic signed [31:0] pos_y_ff, pos_y_in;
   logic [15:0]        speed_ff, speed_in;
   logic [15:0]        heading_ff, heading_in;

   logic signed [CW-1:0] cx_ff, cx_in;
   logic signed [CW-1:0] cy_ff, cy_in;
   logic signed [AW-1:0] cz_ff, cz_in;
   logic signed [MP-1:0] prod_ff, prod_in;
   logic [31:0]          dist_ff, dist_in;

   // Output register, so that a waiting result does not hold off the next request.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [95:0]          rsp_data_ff, rsp_data_in;

   // Shared multiplier and datapath helpers.
   logic signed [MA-1:0] mul_a;
   logic signed [CW-1:0] mul_b;
   logic signed [MP-1:0] mul_p;
   logic signed [MP-1:0] rnd16_sum;
   logic signed [16:0]   rnd16;
   logic signed [17:0]   sp_sum;
   logic [15:0]          sp_sat;
   logic signed [MP-1:0] rnd24_sum;
   logic signed [28:0]   pos_step;
   logic signed [31:0]   pos_base;
   logic signed [33:0]   pos_sum;
   logic signed [31:0]   pos_sat;
   logic signed [CW-1:0] cos_val;
   logic signed [CW-1:0] sin_val;
   logic signed [CW-1:0] dx;
   logic signed [CW-1:0] dy;
   logic signed [AW-1:0] atan_val;
   logic                 iter_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_time_ff     <= udr_pkg::STEP_TIME_RESET;
         start_x_ff       <= '0;
         start_y_ff       <= '0;
         start_speed_ff   <= '0;
         start_heading_ff <= '0;
      end else if (csr_we) begin
         case (udr_pkg::reg_index_type'(csr_index))
            udr_pkg::REG_STEP_TIME:     step_time_ff     <= csr_wdata[15:0];
            udr_pkg::REG_START_X:       start_x_ff       <= csr_wdata;
            udr_pkg::REG_START_Y:       start_y_ff       <= csr_wdata;
            udr_pkg::REG_START_SPEED:   start_speed_ff   <= csr_wdata[15:0];
            udr_pkg::REG_START_HEADING: start_heading_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign mul_p = mul_a * mul_b;

   // Round half up and drop 16 bits: speed and heading increments.
   assign rnd16_sum = prod_ff + MP'(32768);
   assign rnd16     = rnd16_sum[32:16];
   assign sp_sum    = $signed({2'b00, speed_ff}) + 18'(rnd16);

   always_comb begin
      if (sp_sum[17]) begin
         sp_sat = '0;
      end else if (sp_sum[16]) begin
         sp_sat = 16'hFFFF;
      end else begin
         sp_sat = sp_sum[15:0];
      end
   end

   // Round half up and drop 24 bits, then a saturating add to the position.
   assign rnd24_sum = prod_ff + MP'(8388608);
   assign pos_step  = rnd24_sum[52:24];
   assign pos_base  = (state_ff == udr_pkg::S_MUL_S) ? pos_x_ff : pos_y_ff;
   assign pos_sum   = 34'(pos_base) + 34'(pos_step);

   always_comb begin
      if (pos_sum[33] && !(pos_sum[32] && pos_sum[31])) begin
         pos_sat = 32'sh8000_0000;
      end else if (!pos_sum[33] && (pos_sum[32] || pos_sum[31])) begin
         pos_sat = 32'sh7FFF_FFFF;
      end else begin
         pos_sat = pos_sum[31:0];
      end
   end

   // The CORDIC result covers one quadrant; the top heading bits rotate it.
   always_comb begin
      case (heading_ff[15:14])
         udr_pkg::QUAD_0: begin cos_val = cx_ff;  sin_val = cy_ff;  end
         udr_pkg::QUAD_1: begin cos_val = -cy_ff; sin_val = cx_ff;  end
         udr_pkg::QUAD_2: begin cos_val = -cx_ff; sin_val = -cy_ff; end
         default:         begin cos_val = cy_ff;  sin_val = -cx_ff; end
      endcase
   end

   assign dx        = cy_ff >>> iter_ff;
   assign dy        = cx_ff >>> iter_ff;
   assign atan_val  = udr_pkg::atan_turn(iter_ff);
   assign iter_last = (iter_ff == IW'(ITERS - 1));

   always_comb begin
      state_in     = state_ff;
      iter_in      = iter_ff;
      acc_in       = acc_ff;
      yaw_in       = yaw_ff;
      last_in      = last_ff;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      speed_in     = speed_ff;
      heading_in   = heading_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      prod_in      = prod_ff;
      dist_in      = dist_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mul_a        = '0;
      mul_b        = '0;

      case (state_ff)
         udr_pkg::S_IDLE: begin
            if (req_tvalid) begin
               acc_in  = req_tdata[15:0];
               yaw_in  = req_tdata[31:16];
               last_in = req_tlast;
               if (req_tuser) begin
                  pos_x_in   = start_x_ff;
                  pos_y_in   = start_y_ff;
                  speed_in   = start_speed_ff;
                  heading_in = start_heading_ff;
               end
               state_in = udr_pkg::S_MUL_ACC;
            end
         end
         udr_pkg::S_MUL_ACC: begin
            mul_a    = MA'(acc_ff);
            mul_b    = $signed({{(CW-16){1'b0}}, step_time_ff});
            prod_in  = mul_p;
            state_in = udr_pkg::S_MUL_YAW;
         end
         udr_pkg::S_MUL_YAW: begin
            speed_in = sp_sat;
            mul_a    = MA'(yaw_ff);
            mul_b    = $signed({{(CW-16){1'b0}}, step_time_ff});
            prod_in  = mul_p;
            state_in = udr_pkg::S_HEAD;
         end
         udr_pkg::S_HEAD: begin
            heading_in = heading_ff + rnd16_sum[31:16];
            cx_in      = udr_pkg::CORDIC_START;
            cy_in      = '0;
            cz_in      = $signed({2'b00, heading_in[13:0], 16'h0000});
            iter_in    = '0;
            mul_a      = $signed({{(MA-16){1'b0}}, speed_ff});
            mul_b      = $signed({{(CW-16){1'b0}}, step_time_ff});
            dist_in    = mul_p[31:0];
            state_in   = udr_pkg::S_CORDIC;
         end
         udr_pkg::S_CORDIC: begin
            if (!cz_ff[AW-1]) begin
               cx_in = cx_ff - dx;
               cy_in = cy_ff + dy;
               cz_in = cz_ff - atan_val;
            end else begin
               cx_in = cx_ff + dx;
               cy_in = cy_ff - dy;
               cz_in = cz_ff + atan_val;
            end
            iter_in = iter_ff + 1'b1;
            if (iter_last) begin
               state_in = udr_pkg::S_MUL_C;
            end
         end
         udr_pkg::S_MUL_C: begin
            mul_a    = $signed({1'b0, dist_ff});
            mul_b    = cos_val;
            prod_in  = mul_p;
            state_in = udr_pkg::S_MUL_S;
         end
         udr_pkg::S_MUL_S: begin
            pos_x_in = pos_sat;
            mul_a    = $signed({1'b0, dist_ff});
            mul_b    = sin_val;
            prod_in  = mul_p;
            state_in = udr_pkg::S_POS_Y;
         end
         udr_pkg::S_POS_Y: begin
            pos_y_in = pos_sat;
            state_in = last_ff ? udr_pkg::S_OUT : udr_pkg::S_IDLE;
         end
         udr_pkg::S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {heading_ff, speed_ff, pos_y_ff, pos_x_ff};
               state_in     = udr_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = udr_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= udr_pkg::S_IDLE;
         iter_ff      <= '0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         speed_ff     <= '0;
         heading_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         speed_ff     <= speed_in;
         heading_ff   <= heading_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      yaw_ff      <= yaw_in;
      last_ff     <= last_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      prod_ff     <= prod_in;
      dist_ff     <= dist_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == udr_pkg::S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("pending result dropped or changed");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == udr_pkg::S_MUL_ACC))
      else $error("accepted request did not start the sequence");

   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == udr_pkg::S_CORDIC) |-> (iter_ff <= IW'(ITERS - 1)))
      else $error("CORDIC iteration count out of range");

   a_result_from_last_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff != udr_pkg::S_OUT && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("result raised for a non-final sub-step");

   a_speed_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == udr_pkg::S_CORDIC) |=> $stable(speed_ff))
      else $error("speed changed during rotation");
`endif

endmodule

`default_nettype wire
